/* src/sitoa_pkg.sv */
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and types for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  // Fixed width of the input word port
  localparam int IN_W = 64;

  // Bits of the input word that carry the number; the top one is the sign
  localparam int VALUE_WIDTH = 64;

  // Digits in 2^(VALUE_WIDTH-1), the largest magnitude
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

  // Shift-and-add-3 conversion, four bits per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int MAG_W         = CONV_STEPS * BITS_PER_STEP;
  localparam int BCD_W         = NUM_DIGITS * 4;
  localparam int IDX_W         = $clog2(NUM_DIGITS);
  localparam int STEP_W        = $clog2(CONV_STEPS);

  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;

  typedef struct packed {
    logic load;  // take a new word from the input
    logic conv;  // one conversion step
    logic scan;  // find the leading digit
    logic emit;  // load the next character into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;  // current conversion step is the final one
    logic emit_last;  // next character is the final one of the number
    logic out_free;   // output register can take a character this cycle
  } dp_stat_t;

endpackage

/* src/sitoa_ctrl.sv */
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer: accept, convert, find the leading digit, emit characters.
// ----------------------------------------------------------------------------
module sitoa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sitoa_pkg::dp_stat_t stat,
  output sitoa_pkg::dp_cmd_t  cmd
);
  import sitoa_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    SCAN,
    EMIT
  } state_t;

  state_t state;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load = in_valid;
      CONV: cmd.conv = 1'b1;
      SCAN: cmd.scan = 1'b1;
      EMIT: cmd.emit = stat.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: if (in_valid) state <= CONV;
        CONV: if (stat.conv_done) state <= SCAN;
        SCAN: state <= EMIT;
        EMIT: if (stat.out_free && stat.emit_last) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* src/sitoa_dp.sv */
// ----------------------------------------------------------------------------
// sitoa_dp
// Magnitude and BCD registers, digit pointer and output character register.
// ----------------------------------------------------------------------------
module sitoa_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  sitoa_pkg::dp_cmd_t      cmd,
  output sitoa_pkg::dp_stat_t     stat,
  input  logic [sitoa_pkg::IN_W-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             char_code,
  output logic                   last_char
);
  import sitoa_pkg::*;

  logic [MAG_W-1:0]       mag;
  logic [BCD_W-1:0]       bcd;
  logic [STEP_W-1:0]      step_cnt;
  logic [IDX_W-1:0]       dig_idx;
  logic                   sign_pending;

  logic [VALUE_WIDTH-1:0] v_in;
  logic [VALUE_WIDTH-1:0] v_abs;
  logic [MAG_W-1:0]       mag_next;
  logic [BCD_W-1:0]       bcd_next;
  logic [IDX_W-1:0]       first_idx;
  logic [3:0]             cur_digit;

  assign v_in  = value[VALUE_WIDTH-1:0];
  assign v_abs = v_in[VALUE_WIDTH-1] ? (~v_in + 1'b1) : v_in;

  // Four shift-and-add-3 steps per cycle
  always_comb begin
    logic [MAG_W-1:0] m;
    logic [BCD_W-1:0] b;
    m = mag;
    b = bcd;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end
    mag_next = m;
    bcd_next = b;
  end

  // Highest non-zero digit; zero gives the lowest digit
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) first_idx = IDX_W'(i);
    end
  end

  assign cur_digit = bcd[dig_idx*4 +: 4];

  assign stat.conv_done = (step_cnt == STEP_W'(CONV_STEPS - 1));
  assign stat.emit_last = !sign_pending && (dig_idx == '0);
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag          <= MAG_W'(v_abs);
      bcd          <= '0;
      step_cnt     <= '0;
      sign_pending <= v_in[VALUE_WIDTH-1];
    end
    if (cmd.conv) begin
      mag      <= mag_next;
      bcd      <= bcd_next;
      step_cnt <= step_cnt + 1'b1;
    end
    if (cmd.scan) dig_idx <= first_idx;
    if (cmd.emit) begin
      if (sign_pending) begin
        char_code    <= ASCII_MINUS;
        last_char    <= 1'b0;
        sign_pending <= 1'b0;
      end else begin
        char_code <= ASCII_ZERO + {4'd0, cur_digit};
        last_char <= (dig_idx == '0);
        dig_idx   <= dig_idx - 1'b1;
      end
    end
  end

  // Hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character a word.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with the 64-bit word value; the low
// VALUE_WIDTH bits are taken as a two's complement number.
// Output channel: out_valid / out_stall with char_code and last_char. A
// negative number starts with '-', digits follow most significant first
// with no leading zeros, zero gives '0'; last_char marks the final character.
// Timing: after a word is accepted, it is converted by shift-and-add-3,
// four bits a cycle; then the leading digit is found and the first
// character is loaded into the output register; one character follows per
// cycle while out_stall is low.
// in_stall is high from acceptance until the final character is loaded into
// the output register, so the next word enters while that character waits.
// A stall on the output holds the current character and pauses further characters.
// Reset (rst, synchronous) returns to idle and empties the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sitoa_pkg::IN_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 char_code,
  output logic                       last_char
);
  import sitoa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sitoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sitoa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last_char (last_char)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted word did not make the block busy");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == ASCII_MINUS ||
                   (char_code >= ASCII_ZERO && char_code <= ASCII_NINE)))
    else $error("character is neither minus nor a digit");

  a_last_not_minus: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_char) |-> (char_code != ASCII_MINUS))
    else $error("number ended on a minus sign");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_char) |-> in_stall)
    else $error("new word taken before the number was finished");
`endif

endmodule
